// ===== hdl/tlb_with_aging_replacement_defines.svh =====
// Assertion macros for the aging TLB checker.
`ifndef TLB_WITH_AGING_REPLACEMENT_DEFINES_SVH
`define TLB_WITH_AGING_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, masked while in reset.
`define TLBAR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tlbar check failed");

// Next-cycle implication, live through reset.
`define TLBAR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("tlbar check failed");

`endif

// ===== hdl/tlbar_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlbar_pkg;

    localparam int NUM_ENTRIES_DEF = 16;
    localparam int OFFSET_BITS_DEF = 12;
    localparam int MAX_REPORTS     = 16;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] AGE_TOP  = 8'h80;
    localparam logic [7:0] AGE_ZERO = 8'h00;

    typedef logic [1:0] t_code;

    localparam t_code ACT_LOOKUP = 2'd0;
    localparam t_code ACT_FILL   = 2'd1;
    localparam t_code ACT_CLEAR  = 2'd2;

    localparam t_code KIND_HIT   = 2'd0;
    localparam t_code KIND_MISS  = 2'd1;
    localparam t_code KIND_EVICT = 2'd2;
    localparam t_code KIND_DONE  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] virt_address;
        logic [19:0] fill_vpage;
        logic [19:0] fill_ppage;
        logic [3:0]  fill_mode;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [3:0]  entry_index;
        logic [31:0] phys_address;
        logic [3:0]  page_mode;
        logic [19:0] evicted_ppage;
        logic        last_of_run;
    } t_result;

    // Classified operation handed from front to back.
    typedef struct packed {
        t_code       op;
        logic [19:0] vpage;
        logic [19:0] offset;
        logic [19:0] ppage;
        logic [3:0]  mode;
    } t_op;

endpackage

`default_nettype wire

// ===== hdl/tlbar_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlbar_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int ADDRW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [ADDRW-1:0] i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [ADDRW-1:0] i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/tlbar_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlbar_front
    import tlbar_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_op       o_op
);

    logic        r_valid, n_valid;
    t_op         r_op, n_op;
    logic        accept;
    logic [51:0] va_wide;
    logic [31:0] off_mask;

    assign busy    = r_valid && i_q_full;
    assign accept  = start && !busy;
    assign o_push  = r_valid && !i_q_full;
    assign o_op    = r_op;
    assign va_wide  = 52'(i_cmd.virt_address);
    assign off_mask = (32'd1 << OFFSET_BITS) - 32'd1;

    always_comb begin
        n_valid = r_valid && i_q_full;
        n_op    = r_op;
        if (accept) begin
            n_op.op    = i_cmd.action;
            n_op.ppage = i_cmd.fill_ppage;
            n_op.mode  = i_cmd.fill_mode;
            n_op.offset = 20'(i_cmd.virt_address & off_mask);
            case (i_cmd.action)
                ACT_LOOKUP: begin
                    n_valid     = 1'b1;
                    n_op.vpage  = va_wide[OFFSET_BITS +: 20];
                end
                ACT_FILL, ACT_CLEAR: begin
                    n_valid     = 1'b1;
                    n_op.vpage  = i_cmd.fill_vpage;
                end
                default: begin
                    n_op.vpage  = i_cmd.fill_vpage;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;
    end

endmodule

`default_nettype wire

// ===== hdl/tlbar_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlbar_queue
    import tlbar_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_data,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_op       o_data
);

    localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTRW-1:0] LAST_SLOT = PTRW'(QUEUE_DEPTH - 1);

    t_op            r_slot [QUEUE_DEPTH];
    logic [PTRW-1:0] r_wptr, r_rptr;
    logic [CNTW-1:0] r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CNTW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_SLOT) ? '0 : r_wptr + PTRW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_SLOT) ? '0 : r_rptr + PTRW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tlbar_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlbar_back
    import tlbar_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_op_valid,
    input  wire t_op  i_op,
    output logic      o_pop,
    output logic      o_res_valid,
    output t_result   o_res
);

    localparam int IDXW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CNTW = $clog2(MAX_REPORTS + 1);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NUM_ENTRIES - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOOK  = 4'd1;
    localparam logic [3:0] ST_LOUT  = 4'd2;
    localparam logic [3:0] ST_FSEL  = 4'd3;
    localparam logic [3:0] ST_FSCAN = 4'd4;
    localparam logic [3:0] ST_FRD   = 4'd5;
    localparam logic [3:0] ST_FEV   = 4'd6;
    localparam logic [3:0] ST_FDONE = 4'd7;
    localparam logic [3:0] ST_CRD   = 4'd8;
    localparam logic [3:0] ST_CEM   = 4'd9;
    localparam logic [3:0] ST_CDONE = 4'd10;

    logic [3:0]      r_state, n_state;
    t_op             r_op, n_op;
    logic            r_valid [NUM_ENTRIES];
    logic            n_valid [NUM_ENTRIES];
    logic [7:0]      r_age   [NUM_ENTRIES];
    logic [7:0]      n_age   [NUM_ENTRIES];
    logic [19:0]     r_vpage [NUM_ENTRIES];
    logic [19:0]     n_vpage [NUM_ENTRIES];
    logic [IDXW-1:0] r_idx, n_idx;
    logic [IDXW-1:0] r_best, n_best;
    logic [7:0]      r_lowest, n_lowest;
    logic            r_hit, n_hit;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_res_valid, n_res_valid;
    t_result         r_res, n_res;

    logic            hit_any, inval_any;
    logic [IDXW-1:0] hit_idx, inval_idx;
    logic            ram_we;
    logic [IDXW-1:0] ram_raddr;
    logic [23:0]     ram_rdata;
    logic [19:0]     rd_ppage;
    logic [3:0]      rd_mode;
    logic [51:0]     pa_wide;
    logic [IDXW-1:0] res_idx;
    logic [IDXW+3:0] res_idx_wide;

    tlbar_ram #(
        .WIDTH (24),
        .DEPTH (NUM_ENTRIES)
    ) u_ppage_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_best),
        .i_wdata ({r_op.ppage, r_op.mode}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_ppage     = ram_rdata[23:4];
    assign rd_mode      = ram_rdata[3:0];
    assign pa_wide      = (52'(rd_ppage) << OFFSET_BITS) | 52'(r_op.offset);
    assign res_idx      = (r_state == ST_LOUT || r_state == ST_CEM) ? r_idx : r_best;
    assign res_idx_wide = {4'b0000, res_idx};

    // Tag match and first free slot, lowest index first.
    always_comb begin
        hit_any   = 1'b0;
        hit_idx   = '0;
        inval_any = 1'b0;
        inval_idx = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_vpage[i] == r_op.vpage) begin
                hit_any = 1'b1;
                hit_idx = IDXW'(i);
            end
            if (!r_valid[i]) begin
                inval_any = 1'b1;
                inval_idx = IDXW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_valid     = r_valid;
        n_age       = r_age;
        n_vpage     = r_vpage;
        n_idx       = r_idx;
        n_best      = r_best;
        n_lowest    = r_lowest;
        n_hit       = r_hit;
        n_cnt       = r_cnt;
        n_res_valid = 1'b0;
        n_res       = '0;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_raddr   = r_idx;

        case (r_state)
            ST_IDLE: begin
                if (i_op_valid) begin
                    o_pop = 1'b1;
                    n_op  = i_op;
                    case (i_op.op)
                        ACT_LOOKUP: n_state = ST_LOOK;
                        ACT_FILL:   n_state = ST_FSEL;
                        ACT_CLEAR: begin
                            n_idx   = '0;
                            n_cnt   = '0;
                            n_state = ST_CRD;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOOK: begin
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    if (!hit_any || IDXW'(i) <= hit_idx) begin
                        n_age[i] = r_age[i] >> 1;
                    end
                    if (hit_any && IDXW'(i) == hit_idx) begin
                        n_age[i] = (r_age[i] >> 1) | AGE_TOP;
                    end
                end
                n_hit     = hit_any;
                n_idx     = hit_idx;
                ram_raddr = hit_idx;
                n_state   = ST_LOUT;
            end
            ST_LOUT: begin
                n_res_valid       = 1'b1;
                n_res.last_of_run = 1'b1;
                if (r_hit) begin
                    n_res.result_kind  = KIND_HIT;
                    n_res.entry_index  = res_idx_wide[3:0];
                    n_res.phys_address = pa_wide[31:0];
                    n_res.page_mode    = rd_mode;
                end else begin
                    n_res.result_kind  = KIND_MISS;
                end
                n_state = ST_IDLE;
            end
            ST_FSEL: begin
                n_best = '0;
                if (inval_any) begin
                    n_best  = inval_idx;
                    n_state = ST_FRD;
                end else if (NUM_ENTRIES == 1) begin
                    n_state = ST_FRD;
                end else begin
                    n_lowest = r_age[0];
                    n_idx    = IDXW'(1);
                    n_state  = ST_FSCAN;
                end
            end
            ST_FSCAN: begin
                if (r_age[r_idx] < r_lowest) begin
                    n_best   = r_idx;
                    n_lowest = r_age[r_idx];
                end
                if (r_idx == LAST_IDX) begin
                    n_state = ST_FRD;
                end else begin
                    n_idx = r_idx + IDXW'(1);
                end
            end
            ST_FRD: begin
                ram_raddr = r_best;
                n_state   = ST_FEV;
            end
            ST_FEV, ST_FDONE: begin
                n_res_valid       = 1'b1;
                n_res.entry_index = res_idx_wide[3:0];
                if (r_state == ST_FEV && r_valid[r_best]) begin
                    n_res.result_kind   = KIND_EVICT;
                    n_res.evicted_ppage = rd_ppage;
                    n_state             = ST_FDONE;
                end else begin
                    ram_we            = 1'b1;
                    n_vpage[r_best]   = r_op.vpage;
                    n_valid[r_best]   = 1'b1;
                    n_age[r_best]     = AGE_ZERO;
                    n_res.result_kind = KIND_DONE;
                    n_res.last_of_run = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_CRD: begin
                ram_raddr = r_idx;
                if (r_valid[r_idx] && r_cnt < CNTW'(MAX_REPORTS)) begin
                    n_state = ST_CEM;
                end else if (r_idx == LAST_IDX) begin
                    n_state = ST_CDONE;
                end else begin
                    n_idx = r_idx + IDXW'(1);
                end
            end
            ST_CEM: begin
                n_res_valid         = 1'b1;
                n_res.result_kind   = KIND_EVICT;
                n_res.entry_index   = res_idx_wide[3:0];
                n_res.evicted_ppage = rd_ppage;
                n_cnt               = r_cnt + CNTW'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = ST_CDONE;
                end else begin
                    n_idx   = r_idx + IDXW'(1);
                    n_state = ST_CRD;
                end
            end
            ST_CDONE: begin
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    n_valid[i] = 1'b0;
                    n_age[i]   = AGE_ZERO;
                end
                n_res_valid       = 1'b1;
                n_res.result_kind = KIND_DONE;
                n_res.last_of_run = 1'b1;
                n_state           = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                r_valid[i] <= 1'b0;
                r_age[i]   <= AGE_ZERO;
            end
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_valid     <= n_valid;
            r_age       <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_vpage  <= n_vpage;
        r_idx    <= n_idx;
        r_best   <= n_best;
        r_lowest <= n_lowest;
        r_hit    <= n_hit;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// ===== hdl/tlb_with_aging_replacement.sv =====
// Lookup: the front registers the beat and queues it; the back end dequeues it, compares tags with aging,
//   then does a registered read of the page RAM and raises the result strobe.
// Fill: an age scan over the entries runs only when no entry is free.
// Clear: each valid entry, up to MAX_REPORTS of them, is reported with an evict beat, then the done beat.
// A two-deep queue lets the front take new beats while the back end works.
// Synchronous active-low reset: entries invalid, ages zero; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module tlb_with_aging_replacement
    import tlbar_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_cmd i_cmd,
    output logic      busy,
    output logic      o_res_valid,
    output t_result   o_res
);

    logic q_full, q_valid, q_push, q_pop;
    t_op  front_op, q_op;

    tlbar_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_op     (front_op)
    );

    tlbar_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_op),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_op)
    );

    tlbar_back #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .i_op        (q_op),
        .o_pop       (q_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// ===== hdl/tlbar_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "tlb_with_aging_replacement_defines.svh"

module tlbar_checker
    import tlbar_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_res_valid,
    input wire t_result o_res
);

    logic miss_beat, evict_beat, early_beat, quiet_in;
    logic miss_clean, evict_clean;

    assign miss_beat   = o_res_valid && o_res.result_kind == KIND_MISS;
    assign evict_beat  = o_res_valid && o_res.result_kind == KIND_EVICT;
    assign early_beat  = o_res_valid && !o_res.last_of_run;
    assign quiet_in    = !start && !busy;
    assign miss_clean  = o_res.entry_index == 4'd0 && o_res.phys_address == 32'd0 &&
                         o_res.page_mode == 4'd0 && o_res.evicted_ppage == 20'd0;
    assign evict_clean = o_res.phys_address == 32'd0 && o_res.page_mode == 4'd0;

    `TLBAR_ASSERT_IMP(a_only_evict_early, early_beat, o_res.result_kind == KIND_EVICT)
    `TLBAR_ASSERT_IMP(a_miss_clean, miss_beat, miss_clean)
    `TLBAR_ASSERT_IMP(a_evict_fields, evict_beat, evict_clean)
    `TLBAR_ASSERT_NXT(a_reset_quiet, !i_rst_n, !o_res_valid && !busy)
    `TLBAR_ASSERT_NXT(a_busy_needs_beat, quiet_in, !busy)

endmodule

bind tlb_with_aging_replacement tlbar_checker u_tlbar_checker (.*);

`default_nettype wire
